// ===== hw/rtl/b64lw_pkg.sv =====
// Package for the Base64 line-wrapping encoder.
// Holds character constants, the line length and the symbol alphabet function.
// No dependencies.
package b64lw_pkg;

  localparam int unsigned LINE_LENGTH = 76;
  localparam int unsigned COL_W = 7;
  localparam int unsigned MAX_CHARS = 6;

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic ALPHA_STD = 1'b0;
  localparam logic ALPHA_URL = 1'b1;

  localparam logic CFG_ALPHABET = 1'b0;
  localparam logic CFG_WRAP = 1'b1;

  function automatic logic [7:0] sym_to_ascii(input logic [5:0] sym, input logic sel);
    logic [7:0] s;
    logic [7:0] r;
    s = {2'b00, sym};
    if (sym < 6'd26) begin
      r = 8'h41 + s;
    end else if (sym < 6'd52) begin
      r = 8'h61 + s - 8'd26;
    end else if (sym < 6'd62) begin
      r = 8'h30 + s - 8'd52;
    end else if (sym == 6'd62) begin
      r = (sel == ALPHA_URL) ? 8'h2D : 8'h2B;
    end else begin
      r = (sel == ALPHA_URL) ? 8'h5F : 8'h2F;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/base64_encoder_line_wrap.sv =====
// Streaming Base64 encoder, one byte per input beat, with optional CR LF line wrap.
// Uses b64lw_pkg for constants and the alphabet function.
// A byte's characters are written to a buffer, then moved one at a time to the output register.
// Throughput: one character per cycle while out_stall is low; a byte yields 1 to 6
// characters, moved out through the single character output register.
// A new byte is taken as the last character of the previous one moves out.
// Reset (rst_n low, synchronous) clears group, carry, column and config.
module base64_encoder_line_wrap (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last_char
);

  logic                         alpha_sel_r;
  logic                         wrap_en_r;
  logic [1:0]                   group_pos_r, group_pos_nxt;
  logic [3:0]                   carry_r, carry_nxt;
  logic [b64lw_pkg::COL_W-1:0]  col_r, col_nxt;

  logic [7:0]                   buf_chars_r [b64lw_pkg::MAX_CHARS];
  logic [7:0]                   slots_nxt [b64lw_pkg::MAX_CHARS];
  logic [2:0]                   buf_idx_r;
  logic [2:0]                   buf_cnt_r, cnt_nxt;
  logic                         buf_last_r;

  logic                         out_valid_r;
  logic [7:0]                   out_char_r;
  logic                         out_last_r;

  logic                         in_accept;
  logic                         out_take;
  logic                         buf_busy;
  logic                         buf_final;
  logic                         move;

  assign out_take  = !out_valid_r || !out_stall;
  assign buf_busy  = buf_idx_r != buf_cnt_r;
  assign buf_final = (buf_idx_r + 3'd1) == buf_cnt_r;
  assign move      = buf_busy && out_take;
  assign in_stall  = buf_busy && !(buf_final && out_take);
  assign in_accept = in_valid && !in_stall;

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

  // character list for the incoming byte
  always_comb begin
    logic [5:0] s0, s1;
    logic [7:0] c [4];
    logic [2:0] n;
    logic [1:0] pos;
    logic [7:0] col_ext;
    logic       found;
    logic [2:0] w;
    logic       ins;
    logic [2:0] ci;
    logic [2:0] jj;
    s0 = '0;
    s1 = '0;
    n = 3'd1;
    found = 1'b0;
    w = '0;
    ci = '0;
    jj = '0;
    pos = (group_pos_r == 2'd3) ? 2'd0 : group_pos_r;
    c[0] = '0;
    c[1] = '0;
    c[2] = b64lw_pkg::CHAR_PAD;
    c[3] = b64lw_pkg::CHAR_PAD;
    group_pos_nxt = group_pos_r;
    carry_nxt = carry_r;
    unique case (pos)
      2'd1: begin
        s0 = {carry_r[1:0], in_data_byte[7:4]};
        s1 = {in_data_byte[3:0], 2'b00};
        n = in_last_byte ? 3'd3 : 3'd1;
        group_pos_nxt = 2'd2;
        carry_nxt = in_data_byte[3:0];
      end
      2'd2: begin
        s0 = {carry_r, in_data_byte[7:6]};
        s1 = in_data_byte[5:0];
        n = 3'd2;
        group_pos_nxt = 2'd0;
        carry_nxt = '0;
      end
      default: begin
        s0 = in_data_byte[7:2];
        s1 = {in_data_byte[1:0], 4'b0000};
        n = in_last_byte ? 3'd4 : 3'd1;
        group_pos_nxt = 2'd1;
        carry_nxt = {2'b00, in_data_byte[1:0]};
      end
    endcase
    c[0] = b64lw_pkg::sym_to_ascii(s0, alpha_sel_r);
    c[1] = b64lw_pkg::sym_to_ascii(s1, alpha_sel_r);

    // first character that fills the line
    col_ext = {1'b0, col_r};
    for (int k = 0; k < 4; k++) begin
      if (!found && (3'(k) < n) &&
          (col_ext + 8'(k + 1) >= 8'(b64lw_pkg::LINE_LENGTH))) begin
        found = 1'b1;
        w = 3'(k);
      end
    end
    col_nxt = found ? b64lw_pkg::COL_W'(n - w - 3'd1)
                    : b64lw_pkg::COL_W'(col_ext + {5'b0, n});
    ins = found && wrap_en_r;
    cnt_nxt = ins ? n + 3'd2 : n;

    for (int j = 0; j < b64lw_pkg::MAX_CHARS; j++) begin
      jj = 3'(j);
      ci = jj;
      slots_nxt[j] = b64lw_pkg::CHAR_PAD;
      if (ins && jj == w + 3'd1) begin
        slots_nxt[j] = b64lw_pkg::CHAR_CR;
      end else if (ins && jj == w + 3'd2) begin
        slots_nxt[j] = b64lw_pkg::CHAR_LF;
      end else begin
        if (ins && jj > w + 3'd2) begin
          ci = jj - 3'd2;
        end
        if (ci < 3'd4) begin
          slots_nxt[j] = c[ci[1:0]];
        end
      end
    end

    if (in_last_byte) begin
      group_pos_nxt = '0;
      carry_nxt = '0;
      col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_sel_r <= b64lw_pkg::ALPHA_STD;
      wrap_en_r   <= 1'b0;
      group_pos_r <= '0;
      carry_r     <= '0;
      col_r       <= '0;
      buf_idx_r   <= '0;
      buf_cnt_r   <= '0;
      buf_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          b64lw_pkg::CFG_ALPHABET: alpha_sel_r <= cfg_data;
          b64lw_pkg::CFG_WRAP:     wrap_en_r   <= cfg_data;
        endcase
      end
      if (in_accept) begin
        group_pos_r <= group_pos_nxt;
        carry_r     <= carry_nxt;
        col_r       <= col_nxt;
        buf_idx_r   <= '0;
        buf_cnt_r   <= cnt_nxt;
        buf_last_r  <= in_last_byte;
      end else if (move) begin
        buf_idx_r <= buf_idx_r + 3'd1;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int j = 0; j < b64lw_pkg::MAX_CHARS; j++) begin
        buf_chars_r[j] <= slots_nxt[j];
      end
    end
    if (move) begin
      out_char_r <= buf_chars_r[buf_idx_r];
      out_last_r <= buf_last_r && buf_final;
    end
  end

endmodule

// ===== sim/b64_enc_checker.sv =====
`timescale 1ns / 1ps
// Checker for base64_encoder_line_wrap: watches config writes and both channels,
// predicts the character stream and compares every output beat. Uses b64lw_pkg.
module b64_enc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic       cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_char,
  input  logic       out_last_char,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } enc_char_t;

  localparam logic [511:0] STD_SET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [511:0] URL_SET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  logic                        alpha_sel;
  logic                        wrap_en;
  logic [1:0]                  grp;
  logic [3:0]                  carry;
  logic [b64lw_pkg::COL_W-1:0] col;

  enc_char_t chars_due[$];
  enc_char_t byte_chars[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    alpha_sel   = b64lw_pkg::ALPHA_STD;
    wrap_en     = 1'b0;
    grp         = '0;
    carry       = '0;
    col         = '0;
  end

  function automatic logic [7:0] glyph(input logic [5:0] v, input logic sel);
    logic [511:0] set;
    set = (sel == b64lw_pkg::ALPHA_URL) ? URL_SET : STD_SET;
    return set[8*(63 - v) +: 8];
  endfunction

  task automatic put_char(input logic [7:0] c);
    byte_chars.push_back('{ch: c, is_last: 1'b0});
    col = col + 1'b1;
    if (col >= b64lw_pkg::LINE_LENGTH) begin
      col = '0;
      if (wrap_en) begin
        byte_chars.push_back('{ch: b64lw_pkg::CHAR_CR, is_last: 1'b0});
        byte_chars.push_back('{ch: b64lw_pkg::CHAR_LF, is_last: 1'b0});
      end
    end
  endtask

  task automatic put_sym(input logic [5:0] v);
    put_char(glyph(v, alpha_sel));
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    byte_chars.delete();
    case (grp)
      2'd1: begin
        put_sym({carry[1:0], b[7:4]});
        carry = b[3:0];
        grp   = 2'd2;
        if (fin) begin
          put_sym({carry, 2'b00});
          put_char(b64lw_pkg::CHAR_PAD);
        end
      end
      2'd2: begin
        put_sym({carry, b[7:6]});
        put_sym(b[5:0]);
        carry = '0;
        grp   = 2'd0;
      end
      default: begin
        put_sym(b[7:2]);
        carry = {2'b00, b[1:0]};
        grp   = 2'd1;
        if (fin) begin
          put_sym({carry[1:0], 4'b0000});
          put_char(b64lw_pkg::CHAR_PAD);
          put_char(b64lw_pkg::CHAR_PAD);
        end
      end
    endcase
    if (fin) begin
      byte_chars[byte_chars.size() - 1].is_last = 1'b1;
      grp   = '0;
      carry = '0;
      col   = '0;
    end
    foreach (byte_chars[i]) chars_due.push_back(byte_chars[i]);
  endtask

  always @(posedge clk) begin
    enc_char_t want;
    if (!rst_n) begin
      alpha_sel = b64lw_pkg::ALPHA_STD;
      wrap_en   = 1'b0;
      grp       = '0;
      carry     = '0;
      col       = '0;
      chars_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == b64lw_pkg::CFG_ALPHABET) alpha_sel = cfg_data;
        else if (cfg_index == b64lw_pkg::CFG_WRAP) wrap_en = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (chars_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat: expected none, actual char %h last %b",
                   $time, out_char, out_last_char);
        end else begin
          want = chars_due.pop_front();
          if (out_char !== want.ch) begin
            mismatches++;
            $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
          end
          if (out_last_char !== want.is_last) begin
            mismatches++;
            $display("%0t: out_last_char expected %b actual %b",
                     $time, want.is_last, out_last_char);
          end
        end
      end
      if (in_valid && !in_stall) encode_byte(in_data_byte, in_last_byte);
    end
    outstanding = chars_due.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Top of the base64_encoder_line_wrap testbench: clock, reset, byte stimulus,
// output back-pressure and verdict. Needs b64lw_pkg and b64_enc_checker.
module tb;

  localparam int PHASE_BYTES = 80;
  localparam int HOLD_LEN    = 300;
  localparam int DRAIN_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic       cfg_index;
  logic       cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       out_last_char;
  int         mismatches;
  int         outstanding;

  bit         calm;
  bit         hold_req;
  logic [7:0] msg_q[$];

  base64_encoder_line_wrap uut (.*);
  b64_enc_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400_000;
    $display("base64_encoder_line_wrap: mismatch");
    $finish;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    int unsigned left;
    left      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && left == 0) begin
        left     = HOLD_LEN;
        hold_req = 1'b0;
      end
      if (left != 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_msg_q();
    foreach (msg_q[i]) send_beat(msg_q[i], i == msg_q.size() - 1);
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_msg(input int len);
    for (int i = 0; i < len; i++) send_beat(pick_byte(), i == len - 1);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic write_settings(input logic alpha, input logic wrap);
    cfg_wr_en <= 1'b1;
    cfg_index <= b64lw_pkg::CFG_ALPHABET;
    cfg_data  <= alpha;
    @(posedge clk);
    cfg_index <= b64lw_pkg::CFG_WRAP;
    cfg_data  <= wrap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic alpha, input logic wrap);
    int sent;
    int len;
    int r;
    sent = 0;
    write_settings(alpha, wrap);
    if (wrap) begin
      // 57 bytes fill one line exactly, so CR LF closes the message
      send_random_msg(57);
      sent = 57;
    end
    while (sent < PHASE_BYTES) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(12, 1);
      else if (r < 85) len = $urandom_range(60, 50);
      else len = $urandom_range(120, 75);
      send_random_msg(len);
      sent += len;
    end
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = b64lw_pkg::CFG_ALPHABET;
    cfg_data     = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one, two and three byte groups, all-zero and all-one bytes,
    // symbols 62 and 63 in both alphabets
    write_settings(b64lw_pkg::ALPHA_STD, 1'b0);
    msg_q = '{8'h00};
    send_msg_q();
    msg_q = '{8'hFF, 8'hFF};
    send_msg_q();
    msg_q = '{8'hFB, 8'hEF, 8'hBE};
    send_msg_q();
    msg_q = '{8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_msg_q();
    drain();
    write_settings(b64lw_pkg::ALPHA_URL, 1'b1);
    msg_q = '{8'hFB, 8'hEF, 8'hBE, 8'hFF, 8'hFF, 8'hFF};
    send_msg_q();
    msg_q = '{8'h00, 8'h00};
    send_msg_q();
    drain();

    run_phase(b64lw_pkg::ALPHA_STD, 1'b1);
    hold_req = 1'b1;
    run_phase(b64lw_pkg::ALPHA_URL, 1'b0);
    calm = 1'b1;
    run_phase(b64lw_pkg::ALPHA_URL, 1'b1);
    calm = 1'b0;
    run_phase(b64lw_pkg::ALPHA_STD, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("base64_encoder_line_wrap: match");
    end else begin
      $display("base64_encoder_line_wrap: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/b64lw_pkg.sv
hw/rtl/base64_encoder_line_wrap.sv
sim/b64_enc_checker.sv
sim/tb.sv
